>>> rtl/core/kcne_pkg.sv
// Shared types and constants for the key change to note event block.
// No dependencies; every other file of the block but kcne_stream_if imports this package.
package kcne_pkg;

  // One lane per key bit of a scanned byte
  localparam int unsigned LANES = 8;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_CHANNEL  = 2'd0,
    REG_VELOCITY = 2'd1,
    REG_OFFSET   = 2'd2,
    REG_NONE     = 2'd3
  } reg_index_t;

  localparam logic [3:0] CHANNEL_RESET  = 4'd1;
  localparam logic [6:0] VELOCITY_RESET = 7'd64;
  localparam logic [6:0] OFFSET_RESET   = 7'd36;

  // Input word: one scanned byte, active low
  typedef struct packed {
    logic [2:0] byte_index;
    logic [7:0] raw_key_bits;
  } key_word_t;

  // Output word: one note event
  typedef struct packed {
    logic       is_note_on;
    logic [6:0] note_number;
    logic [3:0] event_channel;
    logic [6:0] event_velocity;
    logic       last_event;
  } note_word_t;

  // What the lanes found for one byte
  typedef struct packed {
    logic [LANES-1:0]      mask;
    logic [LANES-1:0]      on;
    logic [LANES-1:0][6:0] note;
  } batch_t;

endpackage

>>> rtl/core/kcne_stream_if.sv
// Valid/ready stream channel carrying one word of a packed type.
// Word types come from kcne_pkg.
interface kcne_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/kcne_lane.sv
// One key lane: change detect, event polarity and note number for one bit.
// Depends on kcne_pkg.
module kcne_lane
  import kcne_pkg::*;
#(
  parameter int unsigned LANE_BIT = 0
) (
  input  logic       prev_bit,
  input  logic       pressed_bit,
  input  logic [2:0] byte_index,
  input  logic [6:0] note_offset,
  output logic       changed,
  output logic       on,
  output logic [6:0] note
);

  logic [6:0] key_number;

  // key number is index*8 + bit, wrap the sum to 7 bits
  assign key_number = {1'b0, byte_index, 3'(LANE_BIT)};
  assign changed    = prev_bit ^ pressed_bit;
  assign on         = pressed_bit;
  assign note       = key_number + note_offset;

endmodule

>>> rtl/core/kcne_merge.sv
// Merge stage: holds the lanes' batch and emits its events lowest bit first.
// Depends on kcne_pkg and kcne_stream_if.
module kcne_merge
  import kcne_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  batch_t              load_batch,
  input  logic [3:0]          midi_channel,
  input  logic [6:0]          note_velocity,
  output logic                can_load,
  kcne_stream_if.source       note_out
);

  logic [LANES-1:0]      pend;
  logic [LANES-1:0]      pend_next;
  logic [LANES-1:0]      on_bits;
  logic [LANES-1:0][6:0] notes;
  logic [LANES-1:0]      sel;
  logic [LANES-1:0]      rest;
  logic                  emit;
  logic                  take;
  logic [6:0]            sel_note;
  logic                  out_valid;
  note_word_t            out_word;

  // pick the lowest pending key
  assign sel  = pend & (~pend + LANES'(1));
  assign rest = pend & ~sel;
  assign emit = (pend != '0) && (!out_valid || note_out.ready);
  assign take = emit && (rest == '0);
  assign can_load = (pend == '0) || take;

  always_comb begin
    sel_note = '0;
    for (int i = 0; i < LANES; i++) begin
      sel_note = sel_note | (sel[i] ? notes[i] : 7'd0);
    end
  end

  // advance the pending mask, a new batch replaces an emptied one
  always_comb begin
    pend_next = pend;
    if (emit) begin
      pend_next = rest;
    end
    if (load) begin
      pend_next = load_batch.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // hold batch payload
  always_ff @(posedge clk) begin
    if (load) begin
      on_bits <= load_batch.on;
      notes   <= load_batch.note;
    end
  end

  // output register, drop the word once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (note_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.is_note_on     <= (on_bits & sel) != '0;
      out_word.note_number    <= sel_note;
      out_word.event_channel  <= midi_channel;
      out_word.event_velocity <= note_velocity;
      out_word.last_event     <= (rest == '0);
    end
  end

  assign note_out.valid = out_valid;
  assign note_out.data  = out_word;

  // a batch only enters when the previous one has drained
  assert property (@(posedge clk) disable iff (rst) load |-> can_load)
    else $error("batch loaded over pending events");

  // no batch without a changed key
  assert property (@(posedge clk) disable iff (rst) load |-> (load_batch.mask != '0))
    else $error("empty batch loaded");

  // each emitted event clears exactly its own pending bit
  assert property (@(posedge clk) disable iff (rst)
    (emit && !load) |=> (pend == ($past(pend) & ~$past(sel))))
    else $error("pending mask out of step with emitted events");

  // a last event leaves nothing pending unless a new batch came in
  assert property (@(posedge clk) disable iff (rst)
    (emit && rest == '0 && !load) |=> (pend == '0))
    else $error("events left after last event");

endmodule

>>> rtl/core/key_change_to_note_events.sv
// Key change to note events: a scanned byte enters, the lanes compare it with the
// stored byte, the merge stage emits one note event per changed key.
// The first event of a byte passes the merge stage's pending mask and output register.
// A new byte is taken once the previous byte's last event is emitted, so the single event
// port sets the pace; a byte with no change, or an index beyond the store, makes no event.
// Reset (rst, synchronous) clears the key store and sets channel 1, velocity 64, offset 36.
module key_change_to_note_events
  import kcne_pkg::*;
#(
  parameter int unsigned NUM_KEY_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  kcne_stream_if.sink   key_in,
  kcne_stream_if.source note_out
);

  localparam int unsigned IDX_W = (NUM_KEY_BYTES > 1) ? $clog2(NUM_KEY_BYTES) : 1;

  logic [NUM_KEY_BYTES-1:0][7:0] store;
  logic [3:0]       midi_channel;
  logic [6:0]       note_velocity;
  logic [6:0]       note_offset;
  reg_index_t       reg_sel;
  logic             cfg_write;
  logic             in_fire;
  logic             idx_ok;
  logic [IDX_W-1:0] idx;
  logic [7:0]       pressed;
  logic [7:0]       prev;
  logic [LANES-1:0] lane_changed;
  logic             can_load;
  batch_t           batch;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel  <= CHANNEL_RESET;
      note_velocity <= VELOCITY_RESET;
      note_offset   <= OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CHANNEL:  midi_channel  <= pwdata[3:0];
        REG_VELOCITY: note_velocity <= pwdata[6:0];
        REG_OFFSET:   note_offset   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CHANNEL:  prdata = {28'd0, midi_channel};
      REG_VELOCITY: prdata = {25'd0, note_velocity};
      REG_OFFSET:   prdata = {25'd0, note_offset};
      default:      prdata = '0;
    endcase
  end

  // input side: read the stored byte for this index
  assign key_in.ready = can_load;
  assign in_fire  = key_in.valid && can_load;
  assign idx_ok   = 32'(key_in.data.byte_index) < NUM_KEY_BYTES;
  assign idx      = IDX_W'(key_in.data.byte_index);
  assign pressed  = ~key_in.data.raw_key_bits;
  assign prev     = idx_ok ? store[idx] : pressed;

  // update the key store on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
    end else if (in_fire && idx_ok) begin
      store[idx] <= pressed;
    end
  end

  // one lane per key bit
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    kcne_lane #(.LANE_BIT(g)) u_lane (
      .prev_bit    (prev[g]),
      .pressed_bit (pressed[g]),
      .byte_index  (key_in.data.byte_index),
      .note_offset (note_offset),
      .changed     (lane_changed[g]),
      .on          (batch.on[g]),
      .note        (batch.note[g])
    );
  end

  assign batch.mask = lane_changed;

  kcne_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (in_fire && (lane_changed != '0)),
    .load_batch    (batch),
    .midi_channel  (midi_channel),
    .note_velocity (note_velocity),
    .can_load      (can_load),
    .note_out      (note_out)
  );

endmodule

>>> tb/key_change_to_note_events_tb.sv
`timescale 1ns / 1ps
// Testbench for key_change_to_note_events: scanned key bytes in, note events out,
// checked against a predictor of the key store. Needs kcne_pkg, kcne_stream_if and the block.
module key_change_to_note_events_tb;
  import kcne_pkg::*;

  localparam int unsigned KEY_BYTES = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 6;
  localparam int BYTES_PER_PHASE = 38;
  localparam int REPORT_LIMIT = 10;
  // Expectation of a directed row: taken from the predictor, or typed in
  localparam int FROM_PREDICTOR = -1;
  localparam int NO_EVENT = 0;
  localparam int ONE_EVENT = 1;

  typedef enum logic {ROW_KEYS, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    reg_index_t sel;
    logic [31:0] value;
    logic [2:0] idx;
    logic [7:0] raw;
    int         typed;
    note_word_t want;
  } step_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kcne_stream_if #(.word_t(key_word_t))  key_in ();
  kcne_stream_if #(.word_t(note_word_t)) note_out ();

  key_change_to_note_events #(.NUM_KEY_BYTES(KEY_BYTES)) u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .key_in   (key_in),
    .note_out (note_out)
  );

  // Predictor state: pressed keys per byte index and the register copies
  logic [7:0] key_state [KEY_BYTES];
  logic [3:0] cfg_channel;
  logic [6:0] cfg_velocity;
  logic [6:0] cfg_offset;
  note_word_t pending_notes [$];
  note_word_t next_note;

  step_t steps [$];
  int fail_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 30;
  int sink_idle_pct = 30;
  int sink_hold = 0;

  always #5 clk = ~clk;

  // Gap length: mostly short, now and then long
  function automatic int idle_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  function automatic note_word_t one_note(input logic on, input logic [6:0] num,
                                          input logic [3:0] ch, input logic [6:0] vel);
    return {on, num, ch, vel, 1'b1};
  endfunction

  function automatic step_t key_row(input logic [2:0] idx, input logic [7:0] raw,
                                    input int typed, input note_word_t want);
    step_t s;
    s = '0;
    s.kind = ROW_KEYS;
    s.idx = idx;
    s.raw = raw;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic step_t reg_row(input reg_index_t sel, input logic [31:0] value);
    step_t s;
    s = '0;
    s.kind = ROW_REG;
    s.sel = sel;
    s.value = value;
    return s;
  endfunction

  // Compare with the stored keys, if asked queue one event per changed key, update the store
  function automatic void predict_note_events(input logic [2:0] idx, input logic [7:0] raw,
                                              input bit queue_them);
    logic [7:0] pressed;
    logic [7:0] change;
    note_word_t ev;
    int last_pos;
    pressed = ~raw;
    change = key_state[idx] ^ pressed;
    last_pos = -1;
    for (int b = 0; b < LANES; b++) begin
      if (change[b]) last_pos = b;
    end
    for (int b = 0; b < LANES; b++) begin
      if (change[b] && queue_them) begin
        ev.is_note_on = pressed[b];
        ev.note_number = {1'b0, idx, 3'b000} + 7'(b) + cfg_offset;
        ev.event_channel = cfg_channel;
        ev.event_velocity = cfg_velocity;
        ev.last_event = (b == last_pos);
        pending_notes.push_back(ev);
      end
    end
    key_state[idx] = pressed;
  endfunction

  function automatic void apply_reg_write(input reg_index_t sel, input logic [31:0] value);
    case (sel)
      REG_CHANNEL: begin
        cfg_channel = value[3:0];
      end
      REG_VELOCITY: begin
        cfg_velocity = value[6:0];
      end
      REG_OFFSET: begin
        cfg_offset = value[6:0];
      end
      default: begin
      end
    endcase
  endfunction

  // APB write: setup, access, wait for pready, then return to idle
  task automatic write_reg(input reg_index_t sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg_write(sel, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every queued event, then let the pipeline settle
  task automatic wait_idle();
    key_in.valid <= 1'b0;
    while (pending_notes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offer one word, hold it until accepted, record the expectation, maybe idle
  task automatic play_byte(input logic [2:0] idx, input logic [7:0] raw,
                           input int typed, input note_word_t want);
    key_in.valid <= 1'b1;
    key_in.data <= {idx, raw};
    do @(posedge clk); while (!key_in.ready);
    @(negedge clk);
    if (typed == FROM_PREDICTOR) begin
      predict_note_events(idx, raw, 1'b1);
    end else begin
      predict_note_events(idx, raw, 1'b0);
      if (typed == ONE_EVENT) pending_notes.push_back(want);
    end
    if ($urandom_range(1, 100) <= src_idle_pct) begin
      key_in.valid <= 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
  endtask

  // Sink side: random stalls on ready
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      note_out.ready <= 1'b0;
    end else if ($urandom_range(1, 100) <= sink_idle_pct) begin
      sink_hold = idle_len() - 1;
      note_out.ready <= 1'b0;
    end else begin
      note_out.ready <= 1'b1;
    end
  end

  // Check each accepted event against the oldest expectation
  always @(posedge clk) begin
    if (!rst && note_out.valid && note_out.ready) begin
      if (pending_notes.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("unexpected note event: on=%0d note=%0d ch=%0d vel=%0d last=%0d",
                   note_out.data.is_note_on, note_out.data.note_number,
                   note_out.data.event_channel, note_out.data.event_velocity,
                   note_out.data.last_event);
        fail_count++;
      end else begin
        next_note = pending_notes.pop_front();
        if (note_out.data !== next_note) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("note event mismatch: exp on=%0d note=%0d ch=%0d vel=%0d last=%0d",
                     next_note.is_note_on, next_note.note_number, next_note.event_channel,
                     next_note.event_velocity, next_note.last_event);
            $display("  got on=%0d note=%0d ch=%0d vel=%0d last=%0d",
                     note_out.data.is_note_on, note_out.data.note_number,
                     note_out.data.event_channel, note_out.data.event_velocity,
                     note_out.data.last_event);
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    step_t s;
    logic [2:0] idx;
    logic [7:0] raw;
    logic [7:0] flip;
    logic [31:0] value;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_in.valid = 1'b0;
    key_in.data = '0;
    note_out.ready = 1'b0;
    foreach (key_state[k]) key_state[k] = '0;
    cfg_channel = CHANNEL_RESET;
    cfg_velocity = VELOCITY_RESET;
    cfg_offset = OFFSET_RESET;

    // Directed rows: reset values, no change, all keys, extremes, wrap, unused register
    steps.push_back(key_row(3'd0, 8'hFE, ONE_EVENT, one_note(1'b1, 7'd36, 4'd1, 7'd64)));
    steps.push_back(key_row(3'd0, 8'hFE, NO_EVENT, '0));
    steps.push_back(key_row(3'd0, 8'hFF, ONE_EVENT, one_note(1'b0, 7'd36, 4'd1, 7'd64)));
    steps.push_back(key_row(3'd7, 8'h00, FROM_PREDICTOR, '0));
    steps.push_back(key_row(3'd7, 8'hFF, FROM_PREDICTOR, '0));
    steps.push_back(key_row(3'd3, 8'h55, FROM_PREDICTOR, '0));
    steps.push_back(key_row(3'd3, 8'hAA, FROM_PREDICTOR, '0));
    steps.push_back(reg_row(REG_CHANNEL, 32'hFFFF_FFFF));
    steps.push_back(reg_row(REG_VELOCITY, 32'hFFFF_FFFF));
    steps.push_back(reg_row(REG_OFFSET, 32'hFFFF_FFFF));
    steps.push_back(key_row(3'd0, 8'hFE, ONE_EVENT, one_note(1'b1, 7'd127, 4'd15, 7'd127)));
    steps.push_back(key_row(3'd7, 8'h7F, FROM_PREDICTOR, '0));
    steps.push_back(key_row(3'd1, 8'h00, FROM_PREDICTOR, '0));
    steps.push_back(reg_row(REG_NONE, 32'h0000_0000));
    steps.push_back(key_row(3'd2, 8'hFD, ONE_EVENT, one_note(1'b1, 7'd16, 4'd15, 7'd127)));
    steps.push_back(reg_row(REG_CHANNEL, 32'h0000_0000));
    steps.push_back(reg_row(REG_VELOCITY, 32'h0000_0000));
    steps.push_back(reg_row(REG_OFFSET, 32'h0000_0000));
    steps.push_back(key_row(3'd0, 8'hFF, ONE_EVENT, one_note(1'b0, 7'd0, 4'd0, 7'd0)));
    steps.push_back(key_row(3'd1, 8'hFF, FROM_PREDICTOR, '0));
    steps.push_back(key_row(3'd5, 8'h00, FROM_PREDICTOR, '0));
    steps.push_back(key_row(3'd5, 8'h00, NO_EVENT, '0));
    steps.push_back(key_row(3'd2, 8'hFF, FROM_PREDICTOR, '0));

    // Hold reset, then release
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed rows
    foreach (steps[i]) begin
      s = steps[i];
      if (s.kind == ROW_REG) begin
        wait_idle();
        write_reg(s.sel, s.value);
      end else begin
        play_byte(s.idx, s.raw, s.typed, s.want);
      end
    end

    // Random phases: fresh settings, then mostly small key changes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      for (int r = 0; r < 3; r++) begin
        value = (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF : $urandom();
        write_reg(reg_index_t'(r), value);
      end
      if ($urandom_range(0, 1)) write_reg(REG_NONE, $urandom());
      src_idle_pct = (p == 2) ? 0 : $urandom_range(10, 60);
      sink_idle_pct = (p == 2) ? 0 : $urandom_range(10, 60);
      for (int n = 0; n < BYTES_PER_PHASE; n++) begin
        idx = 3'($urandom_range(0, KEY_BYTES - 1));
        case ($urandom_range(0, 9))
          0: begin
            raw = 8'($urandom_range(0, 255));
          end
          1: begin
            raw = ~key_state[idx];
          end
          2: begin
            raw = key_state[idx];
          end
          default: begin
            flip = 8'(1 << $urandom_range(0, 7));
            if ($urandom_range(0, 1)) flip |= 8'(1 << $urandom_range(0, 7));
            raw = ~(key_state[idx] ^ flip);
          end
        endcase
        play_byte(idx, raw, FROM_PREDICTOR, '0);
      end
    end

    // Drain and report
    wait_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/kcne_pkg.sv
rtl/core/kcne_stream_if.sv
rtl/core/kcne_lane.sv
rtl/core/kcne_merge.sv
rtl/core/key_change_to_note_events.sv
tb/key_change_to_note_events_tb.sv
